/* design/assert_macros.svh */
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another on the next edge
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/spc_pkg.sv */
package spc_pkg;

    localparam int MAG_W    = 32;
    localparam int SQ_W     = 64;
    localparam int SUM_W    = 66;
    localparam int ROOT_W   = 32;
    localparam int REM_W    = 35;
    localparam int AXIS_FRAC = 14;
    localparam int QUO_W    = 15;
    localparam int NUM_W    = 47;
    localparam int AXIS_W   = 16;
    localparam int MIN_DEPTH_W = 16;
    localparam logic [QUO_W-1:0] AXIS_ONE = 15'd16384;

    typedef struct packed {
        logic signed [31:0] center_a_x;
        logic signed [31:0] center_a_y;
        logic signed [31:0] center_a_z;
        logic signed [31:0] center_b_x;
        logic signed [31:0] center_b_y;
        logic signed [31:0] center_b_z;
        logic [30:0]        radius_a;
        logic [30:0]        radius_b;
        logic               static_a;
        logic               static_b;
        logic [31:0]        mask_a;
        logic [31:0]        mask_b;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic               manifold_valid;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic [31:0]        depth;
    } t_out_item;

    typedef struct packed {
        logic             hit;
        logic [2:0]       neg;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [MAG_W-1:0] mag_z;
        logic [31:0]      rsum;
    } t_geom_sb;

    typedef struct packed {
        logic            valid;
        t_geom_sb        sb;
        logic [SQ_W-1:0] dsq;
    } t_geom;

endpackage

/* design/spc_front.sv */
module spc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  spc_pkg::t_in_item i_item,
    output spc_pkg::t_geom    o_geom
);
    import spc_pkg::*;

    logic             r1_valid, r1_pass;
    logic [2:0]       r1_neg;
    logic [MAG_W-1:0] r1_mag [3];
    logic [31:0]      r1_rsum;

    logic             r2_valid, r2_pass;
    logic [2:0]       r2_neg;
    logic [MAG_W-1:0] r2_mag [3];
    logic [31:0]      r2_rsum;
    logic [SQ_W-1:0]  r2_sq [3];
    logic [SQ_W-1:0]  r2_rsq;

    logic             r3_valid;
    t_geom_sb         r3_sb;
    logic [SQ_W-1:0]  r3_dsq;

    logic signed [32:0] n_diff [3];
    logic [SUM_W-1:0]   n_sum;

    always_comb begin
        n_diff[0] = {i_item.center_b_x[31], i_item.center_b_x}
                  - {i_item.center_a_x[31], i_item.center_a_x};
        n_diff[1] = {i_item.center_b_y[31], i_item.center_b_y}
                  - {i_item.center_a_y[31], i_item.center_a_y};
        n_diff[2] = {i_item.center_b_z[31], i_item.center_b_z}
                  - {i_item.center_a_z[31], i_item.center_a_z};
        n_sum = {2'b00, r2_sq[0]} + {2'b00, r2_sq[1]} + {2'b00, r2_sq[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pass <= !(i_item.static_a && i_item.static_b)
                       && ((i_item.mask_a & i_item.mask_b) != 32'd0);
            for (int k = 0; k < 3; k++) begin
                r1_neg[k] <= n_diff[k][32];
                r1_mag[k] <= n_diff[k][32] ? MAG_W'(-n_diff[k]) : MAG_W'(n_diff[k]);
            end
            r1_rsum <= {1'b0, i_item.radius_a} + {1'b0, i_item.radius_b};

            r2_pass <= r1_pass;
            r2_neg  <= r1_neg;
            r2_rsum <= r1_rsum;
            for (int k = 0; k < 3; k++) begin
                r2_mag[k] <= r1_mag[k];
                r2_sq[k]  <= r1_mag[k] * r1_mag[k];
            end
            r2_rsq <= r1_rsum * r1_rsum;

            r3_sb.hit   <= r2_pass && (n_sum <= {2'b00, r2_rsq});
            r3_sb.neg   <= r2_neg;
            r3_sb.mag_x <= r2_mag[0];
            r3_sb.mag_y <= r2_mag[1];
            r3_sb.mag_z <= r2_mag[2];
            r3_sb.rsum  <= r2_rsum;
            r3_dsq      <= n_sum[SQ_W-1:0];
        end
    end

    assign o_geom.valid = r3_valid;
    assign o_geom.sb    = r3_sb;
    assign o_geom.dsq   = r3_dsq;

endmodule

/* design/spc_isqrt.sv */
module spc_isqrt #(
    parameter int SB_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [spc_pkg::SQ_W-1:0]   i_num,
    input  logic [SB_W-1:0]            i_sb,
    output logic                       o_valid,
    output logic [spc_pkg::ROOT_W-1:0] o_root,
    output logic [SB_W-1:0]            o_sb
);
    import spc_pkg::*;

    logic              r_v    [ROOT_W+1];
    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];
    logic [SQ_W-1:0]   r_num  [ROOT_W+1];
    logic [SB_W-1:0]   r_sb   [ROOT_W+1];

    assign r_v[0]    = i_valid;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_num[0]  = i_num;
    assign r_sb[0]   = i_sb;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0] n_rem2, n_trial;
        logic             n_take;

        always_comb begin
            n_rem2  = {r_rem[k][REM_W-3:0], r_num[k][SQ_W-1 -: 2]};
            n_trial = {1'b0, r_root[k], 2'b01};
            n_take  = n_rem2 >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_take ? n_rem2 - n_trial : n_rem2;
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], n_take};
                r_num[k+1]  <= {r_num[k][SQ_W-3:0], 2'b00};
                r_sb[k+1]   <= r_sb[k];
            end
        end
    end

    assign o_valid = r_v[ROOT_W];
    assign o_root  = r_root[ROOT_W];
    assign o_sb    = r_sb[ROOT_W];

endmodule

/* design/spc_axis_div.sv */
module spc_axis_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [spc_pkg::NUM_W-1:0]  i_num,
    input  logic [spc_pkg::ROOT_W-1:0] i_den,
    output logic [spc_pkg::QUO_W-1:0]  o_quo
);
    import spc_pkg::*;

    logic [NUM_W-1:0]  r_rem [QUO_W+1];
    logic [ROOT_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0]  r_quo [QUO_W+1];

    assign r_rem[0] = i_num;
    assign r_den[0] = i_den;
    assign r_quo[0] = '0;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int SH = QUO_W - 1 - k;
        logic [NUM_W-1:0] n_sub;
        logic             n_take;

        always_comb begin
            n_sub  = NUM_W'(r_den[k]) << SH;
            n_take = r_rem[k] >= n_sub;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_take ? r_rem[k] - n_sub : r_rem[k];
                r_den[k+1] <= r_den[k];
                r_quo[k+1] <= {r_quo[k][QUO_W-2:0], n_take};
            end
        end
    end

    assign o_quo = r_quo[QUO_W];

endmodule

/* design/sphere_pair_collision.sv */
// Channel   Direction  Handshake              Beat
// input     in         i_valid / o_ready      i_data  (pair of spheres)
// output    out        o_valid / i_ready      o_data  (hit, axis, depth)
// config    in         i_cfg_we               i_cfg_wdata (min_depth)
//
// One pair enters per cycle unless the output stalls; the pipeline has 3 front
// stages, 32 square root stages (one result bit each), 1 numerator stage, 15
// divider stages (one quotient bit each, three lanes) and the output register.
// Synchronous active-low reset clears the valid bits and sets min_depth to 0.
// A result held at the output with i_ready low freezes the whole pipeline.
module sphere_pair_collision (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  spc_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output spc_pkg::t_out_item  o_data,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);
    import spc_pkg::*;
    `include "assert_macros.svh"

    localparam int SB_W = $bits(t_geom_sb);

    logic                   en;
    logic [MIN_DEPTH_W-1:0] r_min_depth;
    t_geom                  geom;
    logic                   sq_valid;
    logic [ROOT_W-1:0]      sq_root;
    t_geom_sb               sq_sb;

    logic                   r_n_valid;
    logic                   r_n_hit;
    logic [2:0]             r_n_neg;
    logic                   r_n_zero;
    logic [31:0]            r_n_depth;
    logic [NUM_W-1:0]       r_n_num [3];
    logic [ROOT_W-1:0]      r_n_den;

    logic                   r_d_valid [QUO_W+1];
    logic                   r_d_hit   [QUO_W+1];
    logic [2:0]             r_d_neg   [QUO_W+1];
    logic                   r_d_zero  [QUO_W+1];
    logic [31:0]            r_d_depth [QUO_W+1];
    logic [QUO_W-1:0]       quo [3];

    logic                   r_out_valid;
    t_out_item              r_out;
    logic [AXIS_W-1:0]      n_axis [3];

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_depth <= '0;
        end else if (i_cfg_we) begin
            r_min_depth <= i_cfg_wdata;
        end
    end

    spc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_data),
        .o_geom  (geom)
    );

    spc_isqrt #(.SB_W(SB_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (geom.valid),
        .i_num   (geom.dsq),
        .i_sb    (geom.sb),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_sb    (sq_sb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (en) begin
            r_n_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_hit    <= sq_sb.hit;
            r_n_neg    <= sq_sb.neg;
            r_n_zero   <= sq_root == '0;
            r_n_depth  <= sq_sb.rsum - sq_root;
            r_n_den    <= sq_root;
            r_n_num[0] <= NUM_W'({sq_sb.mag_x, AXIS_FRAC'(0)}) + NUM_W'(sq_root[ROOT_W-1:1]);
            r_n_num[1] <= NUM_W'({sq_sb.mag_y, AXIS_FRAC'(0)}) + NUM_W'(sq_root[ROOT_W-1:1]);
            r_n_num[2] <= NUM_W'({sq_sb.mag_z, AXIS_FRAC'(0)}) + NUM_W'(sq_root[ROOT_W-1:1]);
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        spc_axis_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_n_num[l]),
            .i_den (r_n_den),
            .o_quo (quo[l])
        );
    end

    assign r_d_valid[0] = r_n_valid;
    assign r_d_hit[0]   = r_n_hit;
    assign r_d_neg[0]   = r_n_neg;
    assign r_d_zero[0]  = r_n_zero;
    assign r_d_depth[0] = r_n_depth;

    for (genvar k = 0; k < QUO_W; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[k+1] <= 1'b0;
            end else if (en) begin
                r_d_valid[k+1] <= r_d_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d_hit[k+1]   <= r_d_hit[k];
                r_d_neg[k+1]   <= r_d_neg[k];
                r_d_zero[k+1]  <= r_d_zero[k];
                r_d_depth[k+1] <= r_d_depth[k];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [QUO_W-1:0] q;
            q = (quo[l] > AXIS_ONE) ? AXIS_ONE : quo[l];
            if (!r_d_hit[QUO_W] || r_d_zero[QUO_W]) begin
                n_axis[l] = '0;
            end else if (r_d_neg[QUO_W][l]) begin
                n_axis[l] = AXIS_W'(-{1'b0, q});
            end else begin
                n_axis[l] = AXIS_W'({1'b0, q});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_d_valid[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.hit            <= r_d_hit[QUO_W];
            r_out.manifold_valid <= r_d_hit[QUO_W]
                                    && (r_d_depth[QUO_W] > {16'd0, r_min_depth});
            r_out.axis_x         <= n_axis[0];
            r_out.axis_y         <= n_axis[1];
            r_out.axis_z         <= n_axis[2];
            r_out.depth          <= r_d_hit[QUO_W] ? r_d_depth[QUO_W] : 32'd0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `CHK_ALWAYS(a_manifold_hit, i_clk, i_rst_n,
        !(o_valid && o_data.manifold_valid && !o_data.hit), "manifold without hit")
    `CHK_ALWAYS(a_miss_zero, i_clk, i_rst_n,
        !(o_valid && !o_data.hit) || (o_data.depth == 32'd0 && o_data.axis_x == 16'sd0
        && o_data.axis_y == 16'sd0 && o_data.axis_z == 16'sd0), "miss with nonzero fields")
    `CHK_ALWAYS(a_axis_range, i_clk, i_rst_n,
        !o_valid || (o_data.axis_x <= 16'sd16384 && o_data.axis_x >= -16'sd16384),
        "axis out of range")
    `CHK_NEXT(a_stall_hold, i_clk, i_rst_n, !o_ready, $stable(o_data) && o_valid,
        "output changed during stall")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import spc_pkg::*;

    localparam int RANDOM_PAIRS = 2000;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        t_in_item  pair;
        bit        typed;
        t_out_item want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_item   i_data = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_item  o_data;
    logic       i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    logic [15:0] min_depth_cfg = '0;
    t_out_item   contact_q[$];
    t_row        rows[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    sphere_pair_collision i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] unit_comp(longint unsigned mag, bit neg,
                                              longint unsigned len);
        longint unsigned q;
        if (len == 0) return '0;
        q = (mag * 64'd16384 + len / 2) / len;
        if (q > 64'd16384) q = 64'd16384;
        if (neg) q = -q;
        return q[15:0];
    endfunction

    function automatic t_out_item predict_contact(t_in_item p);
        t_out_item       r;
        longint signed   d[3];
        longint unsigned mag[3];
        bit              neg[3];
        logic [65:0]     dsq;
        longint unsigned rsum;
        longint unsigned root_len;
        longint unsigned dep;
        r = '0;
        if (p.static_a && p.static_b) return r;
        if ((p.mask_a & p.mask_b) == 0) return r;
        d[0] = longint'(p.center_b_x) - longint'(p.center_a_x);
        d[1] = longint'(p.center_b_y) - longint'(p.center_a_y);
        d[2] = longint'(p.center_b_z) - longint'(p.center_a_z);
        dsq = '0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = d[k] < 0;
            mag[k] = neg[k] ? -d[k] : d[k];
            dsq    = dsq + 66'(mag[k] * mag[k]);
        end
        rsum = longint'(p.radius_a) + longint'(p.radius_b);
        if (dsq > 66'(rsum * rsum)) return r;
        root_len = int_sqrt(dsq[63:0]);
        dep      = rsum - root_len;
        r.hit            = 1'b1;
        r.manifold_valid = dep > min_depth_cfg;
        r.axis_x         = unit_comp(mag[0], neg[0], root_len);
        r.axis_y         = unit_comp(mag[1], neg[1], root_len);
        r.axis_z         = unit_comp(mag[2], neg[2], root_len);
        r.depth          = dep[31:0];
        return r;
    endfunction

    function automatic t_in_item random_pair();
        t_in_item p;
        int       sel;
        int       s;
        logic [32:0] lim;
        p   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 70) begin
            s   = $urandom_range(30);
            lim = (33'd1 << s) - 1;
            p.center_a_x = $signed($urandom) >>> 1;
            p.center_a_y = $signed($urandom) >>> 1;
            p.center_a_z = $signed($urandom) >>> 1;
            p.center_b_x = p.center_a_x + ($signed($urandom) >>> (31 - s));
            p.center_b_y = p.center_a_y + ($signed($urandom) >>> (31 - s));
            p.center_b_z = p.center_a_z + ($signed($urandom) >>> (31 - s));
            p.radius_a   = 31'($urandom & lim[31:0]);
            p.radius_b   = 31'($urandom & lim[31:0]);
            if ($urandom_range(9) == 0) begin
                p.center_b_x = p.center_a_x;
                p.center_b_y = p.center_a_y;
                p.center_b_z = p.center_a_z;
            end
            p.static_b = p.static_a ? 1'b0 : p.static_b;
            p.mask_b   = p.mask_b | (32'd1 << $urandom_range(31)) & p.mask_a;
            if (p.mask_a == 0) p.mask_a = p.mask_b;
        end else if (sel < 80) begin
            p.static_a = 1'b1;
            p.static_b = 1'b1;
        end else if (sel < 90) begin
            p.mask_b = ~p.mask_a;
        end
        return p;
    endfunction

    function automatic t_in_item mk_pair(int ax, int bx, int ra, int rb,
                                         bit sa, bit sb);
        t_in_item p;
        p = '0;
        p.center_a_x = ax;
        p.center_b_x = bx;
        p.radius_a   = 31'(ra);
        p.radius_b   = 31'(rb);
        p.static_a   = sa;
        p.static_b   = sb;
        p.mask_a     = 32'hFFFF_FFFF;
        p.mask_b     = 32'hFFFF_FFFF;
        return p;
    endfunction

    function automatic t_out_item mk_hit(logic [15:0] ax, logic [31:0] dep, bit man);
        t_out_item r;
        r = '0;
        r.hit = 1'b1;
        r.manifold_valid = man;
        r.axis_x = ax;
        r.depth = dep;
        return r;
    endfunction

    task automatic add_row(t_in_item p, bit typed, t_out_item want);
        t_row r;
        r.pair  = p;
        r.typed = typed;
        r.want  = want;
        rows.insert(rows.size(), r);
    endtask

    task automatic send_pair(t_in_item p, bit typed, t_out_item want);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= p;
        do @(posedge i_clk); while (!o_ready);
        contact_q.insert(contact_q.size(), typed ? want : predict_contact(p));
    endtask

    task automatic write_min_depth(logic [15:0] v);
        i_valid     <= 1'b0;
        while (contact_q.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        min_depth_cfg = v;
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++) send_pair(random_pair(), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= $urandom_range(99) >= recv_idle_pct;
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (contact_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %p", o_data);
                end else begin
                    t_out_item w;
                    w = contact_q.pop_front();
                    if (o_data.hit !== w.hit || o_data.manifold_valid !== w.manifold_valid
                        || o_data.axis_x !== w.axis_x || o_data.axis_y !== w.axis_y
                        || o_data.axis_z !== w.axis_z || o_data.depth !== w.depth) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: want %p got %p", w, o_data);
                    end
                end
            end
        end
    end

    initial begin
        t_in_item p;
        t_out_item z;
        z = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mk_pair(0, 0, 100, 100, 1, 1), 1, z);
        p = mk_pair(0, 0, 100, 100, 0, 0);
        p.mask_a = 32'hAAAA_AAAA;
        p.mask_b = 32'h5555_5555;
        add_row(p, 1, z);
        add_row(mk_pair(0, 0, 0, 0, 0, 0), 1, mk_hit(16'h0000, 32'd0, 0));
        add_row(mk_pair(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0), 1,
                mk_hit(16'h0000, 32'hFFFF_FFFE, 1));
        add_row(mk_pair(0, 32'h0002_0000, 32'h1_0000, 32'h1_0000, 0, 1), 1,
                mk_hit(16'h4000, 32'd0, 0));
        add_row(mk_pair(32'h1_0000, 0, 32'h1_0000, 32'h1_0000, 0, 0), 1,
                mk_hit(16'hC000, 32'h1_0000, 1));
        p = mk_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        p.center_a_y = 32'h8000_0000;
        p.center_a_z = 32'h8000_0000;
        p.center_b_y = 32'h7FFF_FFFF;
        p.center_b_z = 32'h7FFF_FFFF;
        add_row(p, 1, z);
        p = mk_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        p.mask_a = 32'h8000_0000;
        add_row(p, 0, z);
        p = mk_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        p.mask_b = 32'h0000_0001;
        p.mask_a = 32'h0000_0001;
        add_row(p, 0, z);
        p = mk_pair(5, 12, 3, 4, 0, 0);
        p.center_b_y = -7;
        p.center_b_z = 9;
        add_row(p, 0, z);
        p = mk_pair(-32'h3_0000, 32'h1_0000, 32'h2_0000, 32'h2_0000, 0, 0);
        p.center_b_y = 32'h3_0000;
        add_row(p, 0, z);
        add_row(mk_pair(0, 32'h0002_0001, 32'h1_0000, 32'h1_0000, 0, 0), 1, z);

        write_min_depth(16'd0);
        send_idle_pct = 36;
        recv_idle_pct = 59;
        foreach (rows[k]) send_pair(rows[k].pair, rows[k].typed, rows[k].want);
        send_random(RANDOM_PAIRS / 3);

        write_min_depth(16'hFFFF);
        send_idle_pct = 59;
        recv_idle_pct = 36;
        add_row(mk_pair(0, 0, 32'h8000, 32'h7FFF, 0, 0), 1,
                mk_hit(16'h0000, 32'h0000_FFFF, 0));
        add_row(mk_pair(0, 0, 32'h8000, 32'h8000, 0, 0), 1,
                mk_hit(16'h0000, 32'h0001_0000, 1));
        send_pair(rows[rows.size() - 2].pair, 1'b1, rows[rows.size() - 2].want);
        send_pair(rows[rows.size() - 1].pair, 1'b1, rows[rows.size() - 1].want);
        send_random(RANDOM_PAIRS / 3);

        write_min_depth(16'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RANDOM_PAIRS / 3);
        i_valid <= 1'b0;

        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
